@@ sv/delivery_payload_parser_top_defines.svh @@
// Assertion macros shared by the payload parser modules.
`ifndef DELIVERY_PAYLOAD_PARSER_TOP_DEFINES_SVH
`define DELIVERY_PAYLOAD_PARSER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define DPP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DPP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/dpp_pkg.sv @@
// Types, constants and lookup functions of the delivery payload parser.
package dpp_pkg;

   localparam int unsigned MAGIC_BYTES    = 8;
   localparam int unsigned SIZE_END       = 16;
   localparam int unsigned HDR_BYTES      = 18;
   localparam int unsigned PREFIX_BYTES   = 7;
   localparam int unsigned HEX_DIGITS_DEF = 64;
   localparam int unsigned COUNT_W        = 17;
   localparam int unsigned SIZE_W         = 64;
   localparam int unsigned LEN_W          = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   localparam logic KIND_KEY    = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_BAD_MAGIC = 3'd3,
      ST_EMPTY_KEY = 3'd4,
      ST_LEN_MISM  = 3'd5,
      ST_BAD_KEY   = 3'd6
   } status_type;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic              kind;
      logic [7:0]        key_byte;
      status_type        status;
      logic [SIZE_W-1:0] size_value;
      logic [LEN_W-1:0]  key_length;
   } result_type;

   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'h57;
         3'd1: b = 8'h59;
         3'd2: b = 8'h52;
         3'd3: b = 8'h45;
         3'd4: b = 8'h4D;
         3'd5: b = 8'h44;
         3'd6: b = 8'h50;
         3'd7: b = 8'h31;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h73;
         3'd1:    b = 8'h68;
         3'd2:    b = 8'h61;
         3'd3:    b = 8'h32;
         3'd4:    b = 8'h35;
         3'd5:    b = 8'h36;
         3'd6:    b = 8'h3A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic is_lower_hex(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66);
   endfunction

endpackage

@@ sv/dpp_parse_core.sv @@
// Parser state and per-item result logic of the delivery payload parser.
`include "delivery_payload_parser_top_defines.svh"

module dpp_parse_core #(
   parameter int unsigned HEX_DIGITS = dpp_pkg::HEX_DIGITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  dpp_pkg::item_type   item,
   input  logic                advance,
   output logic                has_result,
   output dpp_pkg::result_type result
);
   import dpp_pkg::*;

   localparam int unsigned KEY_LEN = PREFIX_BYTES + HEX_DIGITS;

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [SIZE_W-1:0]  size_accum_ff, size_accum_in;
   logic [LEN_W-1:0]   length_accum_ff, length_accum_in;
   logic               magic_good_ff, magic_good_in;
   logic               key_good_ff, key_good_in;

   logic [COUNT_W-1:0] pos;
   logic [COUNT_W-1:0] kp;
   logic               header_done;
   logic [7:0]         b;

   assign pos         = byte_count_ff;
   assign kp          = pos - COUNT_W'(HDR_BYTES);
   assign header_done = (pos >= COUNT_W'(HDR_BYTES));
   assign b           = item.data_byte;

   always_comb begin
      byte_count_in   = byte_count_ff;
      size_accum_in   = size_accum_ff;
      length_accum_in = length_accum_ff;
      magic_good_in   = magic_good_ff;
      key_good_in     = key_good_ff;
      if (item_valid && advance) begin
         unique case (item.action)
            ACT_BYTE: begin
               if (pos != COUNT_MAX) begin
                  byte_count_in = pos + COUNT_W'(1);
               end
               if (pos < COUNT_W'(MAGIC_BYTES)) begin
                  if (b != magic_byte(pos[2:0])) begin
                     magic_good_in = 1'b0;
                  end
               end else if (pos < COUNT_W'(SIZE_END)) begin
                  size_accum_in[{pos[2:0], 3'b000} +: 8] =
                     size_accum_ff[{pos[2:0], 3'b000} +: 8] | b;
               end else if (pos < COUNT_W'(HDR_BYTES)) begin
                  length_accum_in[{pos[0], 3'b000} +: 8] =
                     length_accum_ff[{pos[0], 3'b000} +: 8] | b;
               end else begin
                  if (kp < COUNT_W'(PREFIX_BYTES)) begin
                     if (b != prefix_byte(kp[2:0])) begin
                        key_good_in = 1'b0;
                     end
                  end else if (kp < COUNT_W'(KEY_LEN)) begin
                     if (!is_lower_hex(b)) begin
                        key_good_in = 1'b0;
                     end
                  end else begin
                     key_good_in = 1'b0;
                  end
               end
            end
            ACT_END: begin
               byte_count_in   = '0;
               size_accum_in   = '0;
               length_accum_in = '0;
               magic_good_in   = 1'b1;
               key_good_in     = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      has_result        = item_valid && ((item.action == ACT_END) || header_done);
      result.kind       = KIND_KEY;
      result.key_byte   = b;
      result.status     = ST_OK;
      result.size_value = '0;
      result.key_length = '0;
      if (item.action == ACT_END) begin
         result.kind     = KIND_STATUS;
         result.key_byte = '0;
         priority if (pos == '0) begin
            result.status = ST_EMPTY;
         end else if (!header_done) begin
            result.status = ST_TRUNCATED;
         end else if (!magic_good_ff) begin
            result.status = ST_BAD_MAGIC;
         end else if (length_accum_ff == '0) begin
            result.status = ST_EMPTY_KEY;
         end else if (pos != COUNT_W'(HDR_BYTES) + COUNT_W'(length_accum_ff)) begin
            result.status = ST_LEN_MISM;
         end else if (!key_good_ff || length_accum_ff != LEN_W'(KEY_LEN)) begin
            result.status = ST_BAD_KEY;
         end else begin
            result.status = ST_OK;
         end
         if (header_done) begin
            result.size_value = size_accum_ff;
            result.key_length = length_accum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         size_accum_ff   <= '0;
         length_accum_ff <= '0;
         magic_good_ff   <= 1'b1;
         key_good_ff     <= 1'b1;
      end else begin
         byte_count_ff   <= byte_count_in;
         size_accum_ff   <= size_accum_in;
         length_accum_ff <= length_accum_in;
         magic_good_ff   <= magic_good_in;
         key_good_ff     <= key_good_in;
      end
   end

   `DPP_ASSERT_NXT(a_end_clears, clock, reset,
      item_valid && advance && item.action == ACT_END,
      byte_count_ff == '0 && magic_good_ff && key_good_ff && length_accum_ff == '0,
      "end item did not clear parser state")
   `DPP_ASSERT_NXT(a_byte_counts, clock, reset,
      item_valid && advance && item.action == ACT_BYTE,
      byte_count_ff != '0,
      "payload byte left byte count at zero")

endmodule

@@ sv/dpp_out_reg.sv @@
// Result register of the delivery payload parser.
module dpp_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  dpp_pkg::result_type load_data,
   input  logic                rsp_stall,
   output logic                out_free,
   output logic                rsp_valid,
   output dpp_pkg::result_type rsp_data
);
   import dpp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign out_free  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ sv/delivery_payload_parser_top.sv @@
// Top level of the delivery payload parser: input register, parser core, result register.
//
// Input channel req_: one item per handshake, req_action selects a payload byte
// (req_data_byte) or the end of the payload. Result channel rsp_: an echoed key
// byte (rsp_kind 0) for every payload byte at offset 18 or later, and one status
// item (rsp_kind 1) with the decoded size and key length for every end item.
// Header bytes produce no result.
// Path: an accepted item lands in the input register, and its result is then loaded into the
// result register, whose valid flag drives rsp_valid; rsp_stall can hold the item in the
// input register before that load.
// Throughput: one item per cycle while no result waits under rsp_stall, set by the state
// update between the input register and the result register.
// Stall: while rsp_stall holds a waiting result, items that produce no result still
// drain; an item with a result waits in the input register and req_stall rises
// once that register is occupied and cannot advance.
// Reset: synchronous, active high; clears both registers' valid flags and returns
// the parser to the start of a payload.
`include "delivery_payload_parser_top_defines.svh"

module delivery_payload_parser_top #(
   parameter int unsigned HEX_DIGITS = dpp_pkg::HEX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [7:0]                    rsp_key_byte,
   output logic [2:0]                    rsp_status,
   output logic [dpp_pkg::SIZE_W-1:0]    rsp_size_value,
   output logic [dpp_pkg::LEN_W-1:0]     rsp_key_length
);
   import dpp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       move;
   logic       has_result;
   logic       out_free;
   logic       accept;
   result_type result;
   result_type rsp_data;

   assign move      = in_valid_ff && (out_free || !has_result);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (accept) begin
         in_valid_in          = 1'b1;
         in_item_in.action    = req_action;
         in_item_in.data_byte = req_data_byte;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   dpp_parse_core #(
      .HEX_DIGITS (HEX_DIGITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .advance    (move),
      .has_result (has_result),
      .result     (result)
   );

   dpp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (move && has_result),
      .load_data (result),
      .rsp_stall (rsp_stall),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind       = rsp_data.kind;
   assign rsp_key_byte   = rsp_data.key_byte;
   assign rsp_status     = rsp_data.status;
   assign rsp_size_value = rsp_data.size_value;
   assign rsp_key_length = rsp_data.key_length;

   `DPP_ASSERT_IMP(a_rise_from_move, clock, reset,
      $rose(rsp_valid), $past(move && has_result),
      "result appeared without an item moving out of the input register")
   `DPP_ASSERT_IMP(a_key_item_clean, clock, reset,
      rsp_valid && rsp_kind == KIND_KEY,
      rsp_status == ST_OK && rsp_size_value == '0 && rsp_key_length == '0,
      "key byte item carries status fields")

endmodule
